### rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared constants, codes and control types of the KMP substring matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W       = 8;
	localparam int KIND_W      = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_PATTERN = 2'd1,
		KIND_TEXT    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIMPLE,
		ST_FETCH,
		ST_WALK
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic follow;
		logic commit;
	} kmp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic found;
		logic walk_done;
		logic slot_free;
	} kmp_status_t;

endpackage

### rtl/kmp_if.sv
// ----------------------------------------------------------------------------
// kmp_in_if / kmp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kmp_in_if import kmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SYM_W-1:0]  symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface kmp_out_if import kmp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [LEN_W-1:0] progress;
	logic [LEN_W-1:0] pattern_length;
	logic             overflow;

	modport source (output valid, output found, output progress, output pattern_length,
		output overflow, input ready);
	modport sink (input valid, input found, input progress, input pattern_length,
		input overflow, output ready);
endinterface

### rtl/kmp_ram.sv
// ----------------------------------------------------------------------------
// kmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: takes a request, walks the failure chain, commits the result.
// ----------------------------------------------------------------------------
module kmp_ctrl import kmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	input  kmp_status_t       status,
	output kmp_cmd_t          cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (kind_t'(in_kind))
						KIND_PATTERN: begin
							// first byte or full store needs no chain walk
							state_d = (status.full || status.empty) ? ST_SIMPLE : ST_FETCH;
						end
						KIND_TEXT: begin
							state_d = (status.found || status.empty) ? ST_SIMPLE : ST_WALK;
						end
						KIND_CLEAR, KIND_NONE: begin
							state_d = ST_SIMPLE;
						end
					endcase
				end
			end
			ST_SIMPLE: begin
				if (status.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FETCH: begin
				cmd.follow = 1'b1;
				state_d    = ST_WALK;
			end
			ST_WALK: begin
				if (!status.walk_done) begin
					cmd.follow = 1'b1;
				end else if (status.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

endmodule

### rtl/kmp_datapath.sv
// ----------------------------------------------------------------------------
// kmp_datapath
// Pattern and failure memories, match pointer, lengths and result register.
// ----------------------------------------------------------------------------
module kmp_datapath import kmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  kmp_cmd_t          cmd,
	output kmp_status_t       status,
	input  logic [KIND_W-1:0] in_kind,
	input  logic [SYM_W-1:0]  in_symbol,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [LEN_W-1:0]  progress,
	output logic [LEN_W-1:0]  pattern_length,
	output logic              overflow
);

	kind_t            kind_q;
	logic [SYM_W-1:0] sym_q;
	logic [LEN_W-1:0] q_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] mp_q;
	logic             found_q;
	logic             ovf_q;
	logic             out_valid_q;

	logic [LEN_W-1:0] q_next;
	logic [IDX_W-1:0] addr_p;
	logic [IDX_W-1:0] addr_f;
	logic [SYM_W-1:0] p_rd;
	logic [LEN_W-1:0] f_rd;
	logic [LEN_W-1:0] q_fin;
	logic             full;
	logic             empty;

	logic [LEN_W-1:0] len_d;
	logic [LEN_W-1:0] mp_d;
	logic             found_d;
	logic             ovf_d;
	logic             wr_en;
	logic [LEN_W-1:0] f_wr;

	assign full  = (len_q == LEN_W'(MAX_PATTERN));
	assign empty = (len_q == '0);

	// depth whose pattern byte and failure link are read for the next cycle
	always_comb begin
		priority if (cmd.load) begin
			q_next = (kind_t'(in_kind) == KIND_PATTERN) ? len_q : mp_q;
		end else if (cmd.follow) begin
			q_next = f_rd;
		end else begin
			q_next = q_q;
		end
	end

	assign addr_p = q_next[IDX_W-1:0];
	assign addr_f = IDX_W'(q_next - LEN_W'(1));

	assign q_fin = (p_rd == sym_q) ? q_q + LEN_W'(1) : q_q;

	always_comb begin
		len_d   = len_q;
		mp_d    = mp_q;
		found_d = found_q;
		ovf_d   = 1'b0;
		wr_en   = 1'b0;
		f_wr    = '0;
		unique case (kind_q)
			KIND_CLEAR: begin
				len_d   = '0;
				mp_d    = '0;
				found_d = 1'b0;
			end
			KIND_PATTERN: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					wr_en = 1'b1;
					f_wr  = empty ? '0 : q_fin;
					len_d = len_q + LEN_W'(1);
				end
			end
			KIND_TEXT: begin
				if (!found_q) begin
					if (empty) begin
						found_d = 1'b1;
					end else if (q_fin >= len_q) begin
						mp_d    = len_q;
						found_d = 1'b1;
					end else begin
						mp_d = q_fin;
					end
				end
			end
			KIND_NONE: begin
			end
		endcase
	end

	kmp_ram #(
		.WIDTH (SYM_W),
		.DEPTH (MAX_PATTERN)
	) u_pattern_ram (
		.clk   (clk),
		.we    (cmd.commit && wr_en),
		.waddr (len_q[IDX_W-1:0]),
		.wdata (sym_q),
		.raddr (addr_p),
		.rdata (p_rd)
	);

	kmp_ram #(
		.WIDTH (LEN_W),
		.DEPTH (MAX_PATTERN)
	) u_failure_ram (
		.clk   (clk),
		.we    (cmd.commit && wr_en),
		.waddr (len_q[IDX_W-1:0]),
		.wdata (f_wr),
		.raddr (addr_f),
		.rdata (f_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q <= in_symbol;
		end
		q_q <= q_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_NONE;
			len_q       <= '0;
			mp_q        <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				kind_q <= kind_t'(in_kind);
			end
			if (cmd.commit) begin
				len_q       <= len_d;
				mp_q        <= mp_d;
				found_q     <= found_d;
				ovf_q       <= ovf_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.full      = full;
	assign status.empty     = empty;
	assign status.found     = found_q;
	assign status.walk_done = (q_q == '0) || (p_rd == sym_q);
	assign status.slot_free = !out_valid_q || out_ready;

	// state only moves at a commit, so the result reads straight from it
	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign progress       = mp_q;
	assign pattern_length = len_q;
	assign overflow       = ovf_q;

endmodule

### rtl/kmp_substring_matcher_top.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher_top
// Knuth-Morris-Pratt substring detector with online failure table build.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind[1:0], symbol[7:0]
//   out_ch   out  valid/ready    found, progress[6:0], pattern_length[6:0], overflow
//
// clear, dropped append, first append, unused kind and settled text: load, then
// commit; text byte: load, then follow failure links, one link per cycle, then
// commit; append byte: load, fetch, then follow failure links, then commit;
// each link is followed through the registered read of the pattern and
// failure memories; arst_n clears lengths, pointer and flags, memories are not
// cleared; a new request is taken while the previous result waits on out_ch
// ----------------------------------------------------------------------------
module kmp_substring_matcher_top import kmp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	kmp_in_if.sink    in_ch,
	kmp_out_if.source out_ch
);

	kmp_cmd_t    cmd;
	kmp_status_t status;

	kmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	kmp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_kind        (in_ch.kind),
		.in_symbol      (in_ch.symbol),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.found          (out_ch.found),
		.progress       (out_ch.progress),
		.pattern_length (out_ch.pattern_length),
		.overflow       (out_ch.overflow)
	);

	a_progress_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.progress <= out_ch.pattern_length)
		else $error("match pointer beyond pattern length");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.pattern_length <= LEN_W'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.overflow |-> out_ch.pattern_length == LEN_W'(MAX_PATTERN))
		else $error("overflow reported with room left");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_ch.valid)
		else $error("committed request gave no result");

endmodule
